>>> src/crc16_command_frame_builder_defines.svh
// Assertion macros for the CRC-16 command frame builder.
// No dependencies; included by the top level.
`ifndef CRC16_COMMAND_FRAME_BUILDER_DEFINES_SVH
`define CRC16_COMMAND_FRAME_BUILDER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CFB_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CFB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/crcfb_pkg.sv
// Shared types, constants and the CRC fold for the command frame builder.
// No dependencies.
`default_nettype none

package crcfb_pkg;

    localparam logic [1:0]  MODE_BEGIN = 2'd0;
    localparam logic [1:0]  MODE_DATA  = 2'd1;
    localparam logic [1:0]  MODE_END   = 2'd2;

    localparam logic [1:0]  CFG_CRC_ENABLE     = 2'd0;
    localparam logic [1:0]  CFG_ADDR_ENABLE    = 2'd1;
    localparam logic [1:0]  CFG_DEVICE_ADDRESS = 2'd2;

    localparam logic [7:0]  FRAME_HEADER = 8'hEE;
    localparam logic [31:0] FRAME_TAIL   = 32'hFFFC_FFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;

    localparam int STEP_W = 3;

    typedef enum logic [1:0] {
        CMD_BEGIN,
        CMD_DATA,
        CMD_END
    } cmd_kind_t;

    // begin: word = address, flag = addr_enable
    // data:  word[7:0] = byte
    // end:   word = crc, flag = crc_enable
    typedef struct packed {
        cmd_kind_t   kind;
        logic        flag;
        logic [15:0] word;
    } cmd_t;

    typedef struct packed {
        logic [15:0] crc;
    } front_status_t;

    typedef struct packed {
        logic [STEP_W-1:0] step;
    } back_status_t;

    // Reflected CRC-16, one byte, LSB first.
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/crcfb_front.sv
// Front end: config registers, input decode and the running CRC.
// Depends on crcfb_pkg.
`default_nettype none

module crcfb_front (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [15:0]           cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_mode,
    input  wire logic [7:0]            s_data_byte,
    output logic                       push_valid,
    input  wire logic                  push_ready,
    output crcfb_pkg::cmd_t            push_entry,
    output crcfb_pkg::front_status_t   status
);

    logic        crc_enable_reg;
    logic        addr_enable_reg;
    logic [15:0] device_address_reg;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        is_cmd;
    logic        accept;

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_enable_reg     <= 1'b1;
            addr_enable_reg    <= 1'b0;
            device_address_reg <= 16'h0000;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                crcfb_pkg::CFG_CRC_ENABLE:     crc_enable_reg     <= cfg_wdata[0];
                crcfb_pkg::CFG_ADDR_ENABLE:    addr_enable_reg    <= cfg_wdata[0];
                crcfb_pkg::CFG_DEVICE_ADDRESS: device_address_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // decode
    always_comb begin
        is_cmd          = 1'b1;
        crc_next        = crc_reg;
        push_entry.kind = crcfb_pkg::CMD_DATA;
        push_entry.flag = 1'b0;
        push_entry.word = {8'h00, s_data_byte};
        unique case (s_mode)
            crcfb_pkg::MODE_BEGIN: begin
                push_entry.kind = crcfb_pkg::CMD_BEGIN;
                push_entry.flag = addr_enable_reg;
                push_entry.word = device_address_reg;
                crc_next        = crcfb_pkg::CRC_INIT;
            end
            crcfb_pkg::MODE_DATA: begin
                crc_next = crcfb_pkg::crc16_fold(crc_reg, s_data_byte);
            end
            crcfb_pkg::MODE_END: begin
                push_entry.kind = crcfb_pkg::CMD_END;
                push_entry.flag = crc_enable_reg;
                push_entry.word = crc_reg;
            end
            default: begin
                is_cmd = 1'b0;   // unused mode: dropped
            end
        endcase
    end

    assign push_valid = s_valid && is_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= crcfb_pkg::CRC_INIT;
        end else if (accept) begin
            crc_reg <= crc_next;
        end
    end

    assign status.crc = crc_reg;

endmodule

`default_nettype wire

>>> src/crcfb_queue.sv
// Small command queue between front and back ends.
// Depends on crcfb_pkg.
`default_nettype none

module crcfb_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire crcfb_pkg::cmd_t push_entry,
    output logic                 pop_valid,
    input  wire logic            pop,
    output crcfb_pkg::cmd_t      pop_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    crcfb_pkg::cmd_t entries [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_entry  = entries[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/crcfb_back.sv
// Back end: expands each queued command into frame bytes, one per cycle while m_ready is high.
// Depends on crcfb_pkg.
`default_nettype none

module crcfb_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cmd_valid,
    input  wire crcfb_pkg::cmd_t      cmd,
    output logic                      cmd_pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [7:0]                m_out_byte,
    output logic                      m_run_last,
    output crcfb_pkg::back_status_t   status
);

    logic [crcfb_pkg::STEP_W-1:0] step_reg;
    logic [crcfb_pkg::STEP_W-1:0] step_next;
    logic [crcfb_pkg::STEP_W-1:0] end_idx;
    logic                         m_valid_reg;
    logic [7:0]                   out_byte_reg;
    logic                         run_last_reg;
    logic [7:0]                   byte_next;
    logic                         last_next;
    logic                         load;

    // without CRC the end frame skips the two CRC slots
    assign end_idx = step_reg + (cmd.flag ? 3'd0 : 3'd2);

    always_comb begin
        byte_next = 8'h00;
        last_next = 1'b1;
        unique case (cmd.kind)
            crcfb_pkg::CMD_BEGIN: begin
                case (step_reg)
                    3'd0:    byte_next = crcfb_pkg::FRAME_HEADER;
                    3'd1:    byte_next = cmd.word[15:8];
                    default: byte_next = cmd.word[7:0];
                endcase
                last_next = (step_reg == (cmd.flag ? 3'd2 : 3'd0));
            end
            crcfb_pkg::CMD_DATA: begin
                byte_next = cmd.word[7:0];
                last_next = 1'b1;
            end
            crcfb_pkg::CMD_END: begin
                case (end_idx)
                    3'd0:    byte_next = cmd.word[15:8];
                    3'd1:    byte_next = cmd.word[7:0];
                    3'd2:    byte_next = crcfb_pkg::FRAME_TAIL[31:24];
                    3'd3:    byte_next = crcfb_pkg::FRAME_TAIL[23:16];
                    3'd4:    byte_next = crcfb_pkg::FRAME_TAIL[15:8];
                    default: byte_next = crcfb_pkg::FRAME_TAIL[7:0];
                endcase
                last_next = (end_idx == 3'd5);
            end
            default: begin
                byte_next = 8'h00;
                last_next = 1'b1;
            end
        endcase
    end

    assign load      = cmd_valid && (!m_valid_reg || m_ready);
    assign cmd_pop   = load && last_next;
    assign step_next = last_next ? '0 : step_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                step_reg    <= step_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_byte_reg <= byte_next;
            run_last_reg <= last_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = out_byte_reg;
    assign m_run_last  = run_last_reg;
    assign status.step = step_reg;

endmodule

`default_nettype wire

>>> src/crc16_command_frame_builder.sv
// Top level of the CRC-16 (Modbus) command frame builder.
// Depends on crcfb_pkg, crcfb_front, crcfb_queue, crcfb_back and the defines header.
//
// Usage:
//   Input channel (s_valid/s_ready): one item per request. s_mode 0 opens a
//   frame (header 0xEE, optional device address), 1 sends s_data_byte and
//   folds it into the CRC, 2 closes the frame (optional CRC high/low, then
//   FF FC FF FF). Mode 3 is accepted and dropped.
//   Output channel (m_valid/m_ready): one byte per item; m_run_last marks
//   the final byte produced by a request.
//   Config port: cfg_wr_en writes cfg_wdata into register cfg_index
//   (0 crc_enable, 1 addr_enable, 2 device_address); index 3 is ignored.
//   The first byte of a request is registered in the queue, then in the
//   output register, before it is shown.
//   Throughput: one output byte per cycle while m_ready is high, set by the
//   single back-end output register; payload gives 1 byte, a begin 1 or 3,
//   an end 4 or 6. The front accepts one item per cycle while the queue has room.
//   Reset: config returns to crc_enable=1, addr_enable=0, address 0; CRC is
//   0xFFFF; queue and output are empty. No clearing pass is needed.
//   Stall: when m_ready is low the byte holds; the queue keeps taking items
//   until QUEUE_DEPTH commands are waiting, then s_ready drops.
`default_nettype none
`include "crc16_command_frame_builder_defines.svh"

module crc16_command_frame_builder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // request items
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [7:0]  s_data_byte,
    // frame bytes
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_run_last
);

    logic                     push_valid;
    logic                     push_ready;
    crcfb_pkg::cmd_t          push_entry;
    logic                     q_valid;
    logic                     q_pop;
    crcfb_pkg::cmd_t          q_entry;
    crcfb_pkg::front_status_t front_stat;
    crcfb_pkg::back_status_t  back_stat;

    // front: config, decode, running CRC
    crcfb_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_data_byte (s_data_byte),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry),
        .status      (front_stat)
    );

    // decoupling queue
    crcfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_entry  (q_entry)
    );

    // back: byte sequencer and output register
    crcfb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (q_valid),
        .cmd        (q_entry),
        .cmd_pop    (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_last (m_run_last),
        .status     (back_stat)
    );

    // a begin item restarts the CRC
    `CFB_ASSERT_NEXT(a_begin_crc_init, aclk, aresetn, s_valid && s_ready && (s_mode == crcfb_pkg::MODE_BEGIN), front_stat.crc == crcfb_pkg::CRC_INIT, "CRC not reinitialized after begin item")
    // the sequencer is never mid-command with nothing queued
    `CFB_ASSERT_IMP(a_idle_step_zero, aclk, aresetn, !q_valid, back_stat.step == '0, "back end step nonzero with empty queue")
    // a command leaves the queue only on its last byte
    `CFB_ASSERT_NEXT(a_pop_marks_last, aclk, aresetn, q_pop, m_valid && m_run_last, "queue pop without last byte")

endmodule

`default_nettype wire
